### rtl/icm_pkg.sv
// ----------------------------------------------------------------------------
// icm_pkg
// Shared constants and types for the iteration to color mapper.
// ----------------------------------------------------------------------------
package icm_pkg;

    // Default widths
    localparam int FRACTION_BITS    = 16;
    localparam int PIXEL_INDEX_BITS = 22;
    localparam int COUNT_W          = 16;

    // Register file layout
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_MAX_ITER  = 3'd0,
        REG_OPTIONS   = 3'd1,
        REG_MODE      = 3'd2,
        REG_HUE_BASE  = 3'd3,
        REG_HUE_SPAN  = 3'd4
    } reg_idx_t;

    // both upper codes produce no output
    typedef enum logic [1:0] {
        MODE_HSV      = 2'd0,
        MODE_GRAY     = 2'd1,
        MODE_NONE     = 2'd2,
        MODE_NONE_ALT = 2'd3
    } color_mode_t;

    // Option bit positions
    localparam int OPT_INVERT = 0;
    localparam int OPT_SQUARE = 1;
    localparam int OPT_SQRT   = 2;
    localparam int OPT_STRIPE = 4;

    // Register widths and reset values
    localparam int OPT_W       = 5;
    localparam int HUE_BASE_W  = 9;
    localparam int HUE_SPAN_W  = 10;
    localparam logic [COUNT_W-1:0]    MAX_ITER_RST = 16'd64;
    localparam logic [HUE_SPAN_W-1:0] HUE_SPAN_RST = 10'd360;

    // Hue constants
    localparam int HUE_DEG_W     = 11;
    localparam int DEG_FULL      = 360;
    localparam int DEG_SECTOR    = 60;
    // floor(d/60) == (d*4370)>>18 for every d below 2^11
    localparam int SECTOR_RECIP  = 4370;
    localparam int SECTOR_SHIFT  = 18;
    localparam int CHAN_W        = 8;
    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

endpackage

### rtl/icm_stream_if.sv
// ----------------------------------------------------------------------------
// icm_in_if / icm_out_if
// Valid/ready channels carrying pixel requests and mapped colors.
// ----------------------------------------------------------------------------
interface icm_in_if #(
    parameter int PIXEL_INDEX_BITS = icm_pkg::PIXEL_INDEX_BITS
);
    logic                               valid;
    logic                               ready;
    logic [icm_pkg::COUNT_W-1:0]        iteration_count;
    logic [PIXEL_INDEX_BITS-1:0]        pixel_index;

    modport source (output valid, output iteration_count, output pixel_index, input ready);
    modport sink   (input valid, input iteration_count, input pixel_index, output ready);
endinterface

interface icm_out_if #(
    parameter int PIXEL_INDEX_BITS = icm_pkg::PIXEL_INDEX_BITS
);
    logic                               valid;
    logic                               ready;
    logic [PIXEL_INDEX_BITS-1:0]        out_pixel_index;
    logic [icm_pkg::CHAN_W-1:0]         red;
    logic [icm_pkg::CHAN_W-1:0]         green;
    logic [icm_pkg::CHAN_W-1:0]         blue;

    modport source (output valid, output out_pixel_index, output red, output green,
                    output blue, input ready);
    modport sink   (input valid, input out_pixel_index, input red, input green,
                    input blue, output ready);
endinterface

### rtl/icm_divider.sv
// ----------------------------------------------------------------------------
// icm_divider
// Pipelined restoring divider: quot = (dividend << F) / divisor, one
// quotient bit per stage. Requires dividend <= divisor.
// ----------------------------------------------------------------------------
module icm_divider #(
    parameter int FRACTION_BITS = icm_pkg::FRACTION_BITS,
    parameter int TAG_W         = icm_pkg::PIXEL_INDEX_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [icm_pkg::COUNT_W-1:0]   dividend,
    input  logic [icm_pkg::COUNT_W-1:0]   divisor,
    input  logic [TAG_W-1:0]              in_tag,
    output logic                          out_valid,
    output logic [FRACTION_BITS:0]        quot,
    output logic [TAG_W-1:0]              out_tag
);
    localparam int TW     = FRACTION_BITS + 1;
    localparam int STAGES = TW;
    localparam int CW     = icm_pkg::COUNT_W;

    logic [CW-1:0]    rem_reg   [STAGES];
    logic [TW-1:0]    quot_reg  [STAGES];
    logic [TAG_W-1:0] tag_reg   [STAGES];
    logic             valid_reg [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic [CW:0]      rem_in;
        logic [TW-1:0]    quot_in;
        logic [TAG_W-1:0] tag_in;
        logic             valid_in;
        logic [CW:0]      diff;
        logic             ge;

        if (k == 0) begin : g_first
            assign rem_in   = {1'b0, dividend};
            assign quot_in  = '0;
            assign tag_in   = in_tag;
            assign valid_in = in_valid;
        end
        else begin : g_next
            assign rem_in   = {rem_reg[k-1], 1'b0};
            assign quot_in  = quot_reg[k-1];
            assign tag_in   = tag_reg[k-1];
            assign valid_in = valid_reg[k-1];
        end

        // compare and subtract for this quotient bit
        assign ge   = rem_in >= {1'b0, divisor};
        assign diff = rem_in - {1'b0, divisor};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (adv)
                valid_reg[k] <= valid_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k]  <= ge ? diff[CW-1:0] : rem_in[CW-1:0];
                quot_reg[k] <= {quot_in[TW-2:0], ge};
                tag_reg[k]  <= tag_in;
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign quot      = quot_reg[STAGES-1];
    assign out_tag   = tag_reg[STAGES-1];

endmodule

### rtl/icm_sqrt.sv
// ----------------------------------------------------------------------------
// icm_sqrt
// Pipelined integer square root of (t << F), one root bit per stage.
// ----------------------------------------------------------------------------
module icm_sqrt #(
    parameter int FRACTION_BITS = icm_pkg::FRACTION_BITS,
    parameter int TAG_W         = icm_pkg::PIXEL_INDEX_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [FRACTION_BITS:0]        t_in,
    input  logic [TAG_W-1:0]              in_tag,
    output logic                          out_valid,
    output logic [FRACTION_BITS:0]        root,
    output logic [TAG_W-1:0]              out_tag
);
    localparam int F      = FRACTION_BITS;
    localparam int TW     = F + 1;
    localparam int RW     = 2 * F + 1;
    localparam int XW     = RW + 2;
    localparam int STAGES = TW;

    logic [RW-1:0]    rem_reg   [STAGES];
    logic [TW-1:0]    root_reg  [STAGES];
    logic [TAG_W-1:0] tag_reg   [STAGES];
    logic             valid_reg [STAGES];

    for (genvar j = 0; j < STAGES; j++) begin : g_stage
        localparam int B = F - j;
        logic [RW-1:0]    rem_in;
        logic [TW-1:0]    root_in;
        logic [TAG_W-1:0] tag_in;
        logic             valid_in;
        logic [XW-1:0]    trial;
        logic [XW-1:0]    diff;
        logic             ge;

        if (j == 0) begin : g_first
            assign rem_in   = {t_in, {F{1'b0}}};
            assign root_in  = '0;
            assign tag_in   = in_tag;
            assign valid_in = in_valid;
        end
        else begin : g_next
            assign rem_in   = rem_reg[j-1];
            assign root_in  = root_reg[j-1];
            assign tag_in   = tag_reg[j-1];
            assign valid_in = valid_reg[j-1];
        end

        // (r + 2^B)^2 - r^2 = (r << (B+1)) + 2^(2B)
        assign trial = (XW'(root_in) << (B + 1)) + (XW'(1) << (2 * B));
        assign ge    = XW'(rem_in) >= trial;
        assign diff  = XW'(rem_in) - trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[j] <= 1'b0;
            else if (adv)
                valid_reg[j] <= valid_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[j]  <= ge ? diff[RW-1:0] : rem_in;
                root_reg[j] <= ge ? (root_in | (TW'(1) << B)) : root_in;
                tag_reg[j]  <= tag_in;
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign root      = root_reg[STAGES-1];
    assign out_tag   = tag_reg[STAGES-1];

endmodule

### rtl/iteration_to_color_mapper_core.sv
// ----------------------------------------------------------------------------
// iteration_to_color_mapper_core
// Maps an escape iteration count to an HSV-derived or gray RGB pixel.
// ----------------------------------------------------------------------------
// Fully pipelined: one pixel request is taken every cycle while the pipe
// advances. The depth is set by the normalizing divider and the square
// root unit, each of which resolves one result bit per stage. The whole
// pipe advances together; it holds only while the output register is full
// and not taken. Requests that arrive in the no-output color mode are
// dropped at the input. The user must see that registers are written over
// the APB port only while no pixel is in flight; the block itself does not
// enforce this.
module iteration_to_color_mapper_core #(
    parameter int FRACTION_BITS    = icm_pkg::FRACTION_BITS,
    parameter int PIXEL_INDEX_BITS = icm_pkg::PIXEL_INDEX_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    icm_in_if.sink                           in_ch,
    icm_out_if.source                        out_ch,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [icm_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [icm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [icm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    localparam int F   = FRACTION_BITS;
    localparam int TW  = F + 1;
    localparam int PW  = PIXEL_INDEX_BITS;
    localparam int CW  = icm_pkg::COUNT_W;
    localparam int DW  = icm_pkg::APB_DATA_W;
    localparam int HW  = F + icm_pkg::HUE_DEG_W;
    localparam int RMW = F + 6;
    localparam int RK  = F + 12;
    localparam int RCW = F + 7;
    localparam int SW  = 2 * TW;
    localparam int XSW = 2 * F + 9;
    localparam int CHW = icm_pkg::CHAN_W;

    localparam logic [TW-1:0] ONE  = {1'b1, {F{1'b0}}};
    localparam logic [HW-1:0] FULL = HW'(icm_pkg::DEG_FULL) << F;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RK) + 64'(icm_pkg::DEG_SECTOR) - 64'd1) / 64'(icm_pkg::DEG_SECTOR);
    localparam logic [RCW-1:0] RECIP = RECIP_FULL[RCW-1:0];

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CW-1:0]                  max_iter_reg;
    logic [icm_pkg::OPT_W-1:0]      options_reg;
    logic [1:0]                     mode_reg;
    logic [icm_pkg::HUE_BASE_W-1:0] hue_base_reg;
    logic [icm_pkg::HUE_SPAN_W-1:0] hue_span_reg;
    logic [icm_pkg::REG_IDX_W-1:0]  reg_idx;
    logic                           cfg_wr;

    assign reg_idx = paddr[icm_pkg::APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= icm_pkg::MAX_ITER_RST;
            options_reg  <= '0;
            mode_reg     <= icm_pkg::MODE_HSV;
            hue_base_reg <= '0;
            hue_span_reg <= icm_pkg::HUE_SPAN_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                icm_pkg::REG_MAX_ITER: max_iter_reg <= pwdata[CW-1:0];
                icm_pkg::REG_OPTIONS:  options_reg  <= pwdata[icm_pkg::OPT_W-1:0];
                icm_pkg::REG_MODE:     mode_reg     <= pwdata[1:0];
                icm_pkg::REG_HUE_BASE: hue_base_reg <= pwdata[icm_pkg::HUE_BASE_W-1:0];
                icm_pkg::REG_HUE_SPAN: hue_span_reg <= pwdata[icm_pkg::HUE_SPAN_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (reg_idx)
            icm_pkg::REG_MAX_ITER: prdata = DW'(max_iter_reg);
            icm_pkg::REG_OPTIONS:  prdata = DW'(options_reg);
            icm_pkg::REG_MODE:     prdata = DW'(mode_reg);
            icm_pkg::REG_HUE_BASE: prdata = DW'(hue_base_reg);
            icm_pkg::REG_HUE_SPAN: prdata = DW'(hue_span_reg);
            default:               prdata = '0;
        endcase
    end

    logic [CW-1:0] maxv;
    logic          inv;
    assign maxv = (max_iter_reg == '0) ? CW'(1) : max_iter_reg;
    assign inv  = options_reg[icm_pkg::OPT_INVERT];

    // ------------------------------------------------------------------
    // Pipeline advance: everything moves unless the output is held
    // ------------------------------------------------------------------
    logic out_valid_reg;
    logic adv;
    assign adv         = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = adv;

    // ------------------------------------------------------------------
    // Normalize: t = min(count, max) * ONE / max
    // ------------------------------------------------------------------
    logic [CW-1:0] count_sat;
    logic          accept_valid;
    logic          div_valid;
    logic [TW-1:0] div_t;
    logic [PW-1:0] div_pix;

    assign count_sat    = (in_ch.iteration_count > maxv) ? maxv : in_ch.iteration_count;
    assign accept_valid = in_ch.valid && (mode_reg == icm_pkg::MODE_HSV ||
                                          mode_reg == icm_pkg::MODE_GRAY);

    icm_divider #(
        .FRACTION_BITS(F),
        .TAG_W        (PW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (accept_valid),
        .dividend (count_sat),
        .divisor  (maxv),
        .in_tag   (in_ch.pixel_index),
        .out_valid(div_valid),
        .quot     (div_t),
        .out_tag  (div_pix)
    );

    // ------------------------------------------------------------------
    // Optional square
    // ------------------------------------------------------------------
    logic          sq_valid_reg;
    logic [TW-1:0] sq_t_reg;
    logic [PW-1:0] sq_pix_reg;
    logic [SW-1:0] sq_prod;

    assign sq_prod = SW'(div_t) * SW'(div_t);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_valid_reg <= 1'b0;
        else if (adv)
            sq_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_t_reg   <= options_reg[icm_pkg::OPT_SQUARE] ? sq_prod[F +: TW] : div_t;
            sq_pix_reg <= div_pix;
        end
    end

    // ------------------------------------------------------------------
    // Square root; the unrooted t rides along in the tag
    // ------------------------------------------------------------------
    logic             rt_valid;
    logic [TW-1:0]    rt_root;
    logic [PW+TW-1:0] rt_tag;

    icm_sqrt #(
        .FRACTION_BITS(F),
        .TAG_W        (PW + TW)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (sq_valid_reg),
        .t_in     (sq_t_reg),
        .in_tag   ({sq_pix_reg, sq_t_reg}),
        .out_valid(rt_valid),
        .root     (rt_root),
        .out_tag  (rt_tag)
    );

    // ------------------------------------------------------------------
    // Root select and invert
    // ------------------------------------------------------------------
    logic          iv_valid_reg;
    logic [TW-1:0] iv_t_reg;
    logic [PW-1:0] iv_pix_reg;
    logic [TW-1:0] iv_sel;

    assign iv_sel = options_reg[icm_pkg::OPT_SQRT] ? rt_root : rt_tag[TW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            iv_valid_reg <= 1'b0;
        else if (adv)
            iv_valid_reg <= rt_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            iv_t_reg   <= inv ? (ONE - iv_sel) : iv_sel;
            iv_pix_reg <= rt_tag[TW +: PW];
        end
    end

    // ------------------------------------------------------------------
    // Band parity, hue, gray level and rim flag
    // ------------------------------------------------------------------
    logic           m_valid_reg;
    logic [TW-1:0]  m_t_reg;
    logic [HW-1:0]  m_h_reg;
    logic           m_band_reg;
    logic           m_rim_reg;
    logic [CHW-1:0] m_gray_reg;
    logic [PW-1:0]  m_pix_reg;
    logic [TW+CW-1:0]  band_prod;
    logic [HW-1:0]     span_prod;
    logic [TW+CHW-1:0] gray_prod;

    assign band_prod = (TW+CW)'(iv_t_reg) * (TW+CW)'(maxv);
    assign span_prod = HW'(iv_t_reg) * HW'(hue_span_reg);
    assign gray_prod = ((TW+CHW)'(iv_t_reg) << CHW) - (TW+CHW)'(iv_t_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (adv)
            m_valid_reg <= iv_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_t_reg    <= iv_t_reg;
            m_h_reg    <= (HW'(hue_base_reg) << F) + span_prod;
            m_band_reg <= band_prod[F];
            m_rim_reg  <= inv ? (iv_t_reg == '0) : (iv_t_reg == ONE);
            m_gray_reg <= gray_prod[F +: CHW];
            m_pix_reg  <= iv_pix_reg;
        end
    end

    // ------------------------------------------------------------------
    // Striping, hue wrap and sector
    // ------------------------------------------------------------------
    localparam int SPW = icm_pkg::HUE_DEG_W + 13;

    logic           h1_valid_reg;
    logic [HW-1:0]  h1_h_reg;
    logic [2:0]     h1_sector_reg;
    logic [TW-1:0]  h1_s_reg;
    logic           h1_over_reg;
    logic           h1_rim_reg;
    logic [CHW-1:0] h1_gray_reg;
    logic [PW-1:0]  h1_pix_reg;
    logic           striped;
    logic [HW-1:0]  h_wrap;
    logic [SPW-1:0] sector_prod;

    assign striped     = options_reg[icm_pkg::OPT_STRIPE] && m_band_reg;
    assign h_wrap      = (m_h_reg == FULL) ? '0 : m_h_reg;
    assign sector_prod = SPW'(h_wrap[F +: icm_pkg::HUE_DEG_W]) * SPW'(icm_pkg::SECTOR_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            h1_valid_reg <= 1'b0;
        else if (adv)
            h1_valid_reg <= m_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h1_h_reg      <= h_wrap;
            h1_sector_reg <= sector_prod[icm_pkg::SECTOR_SHIFT +: 3];
            h1_s_reg      <= striped ? m_t_reg : ONE;
            h1_over_reg   <= m_h_reg > FULL;
            h1_rim_reg    <= m_rim_reg;
            if (striped)
                h1_gray_reg <= inv ? '0 : icm_pkg::CHAN_MAX;
            else
                h1_gray_reg <= m_gray_reg;
            h1_pix_reg    <= m_pix_reg;
        end
    end

    // ------------------------------------------------------------------
    // Remainder inside the sector
    // ------------------------------------------------------------------
    logic           h2_valid_reg;
    logic [RMW-1:0] h2_rem_reg;
    logic [2:0]     h2_sector_reg;
    logic [TW-1:0]  h2_s_reg;
    logic           h2_over_reg;
    logic           h2_rim_reg;
    logic [CHW-1:0] h2_gray_reg;
    logic [PW-1:0]  h2_pix_reg;
    logic [HW-1:0]  sector_base;
    logic [HW-1:0]  rem_full;

    assign sector_base = (HW'(h1_sector_reg) * HW'(icm_pkg::DEG_SECTOR)) << F;
    assign rem_full    = h1_h_reg - sector_base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            h2_valid_reg <= 1'b0;
        else if (adv)
            h2_valid_reg <= h1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h2_rem_reg    <= rem_full[RMW-1:0];
            h2_sector_reg <= h1_sector_reg;
            h2_s_reg      <= h1_s_reg;
            h2_over_reg   <= h1_over_reg;
            h2_rim_reg    <= h1_rim_reg;
            h2_gray_reg   <= h1_gray_reg;
            h2_pix_reg    <= h1_pix_reg;
        end
    end

    // ------------------------------------------------------------------
    // Fraction within sector: rem / 60 by reciprocal multiply (exact)
    // ------------------------------------------------------------------
    logic           h3_valid_reg;
    logic [TW-1:0]  h3_f_reg;
    logic [2:0]     h3_sector_reg;
    logic [TW-1:0]  h3_s_reg;
    logic           h3_over_reg;
    logic           h3_rim_reg;
    logic [CHW-1:0] h3_gray_reg;
    logic [PW-1:0]  h3_pix_reg;
    logic [RMW+RCW-1:0] f_prod;

    assign f_prod = (RMW+RCW)'(h2_rem_reg) * (RMW+RCW)'(RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            h3_valid_reg <= 1'b0;
        else if (adv)
            h3_valid_reg <= h2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h3_f_reg      <= f_prod[RK +: TW];
            h3_sector_reg <= h2_sector_reg;
            h3_s_reg      <= h2_s_reg;
            h3_over_reg   <= h2_over_reg;
            h3_rim_reg    <= h2_rim_reg;
            h3_gray_reg   <= h2_gray_reg;
            h3_pix_reg    <= h2_pix_reg;
        end
    end

    // ------------------------------------------------------------------
    // Saturation times hue weight, and the floor channel m
    // ------------------------------------------------------------------
    logic           x1_valid_reg;
    logic [SW-1:0]  x1_sw_reg;
    logic [TW-1:0]  x1_oms_reg;
    logic [CHW-1:0] x1_m_reg;
    logic [2:0]     x1_sector_reg;
    logic           x1_over_reg;
    logic           x1_rim_reg;
    logic [CHW-1:0] x1_gray_reg;
    logic [PW-1:0]  x1_pix_reg;
    logic [TW-1:0]  weight;
    logic [TW-1:0]  oms;
    logic [TW+CHW-1:0] m_prod;

    assign weight = h3_sector_reg[0] ? (ONE - h3_f_reg) : h3_f_reg;
    assign oms    = ONE - h3_s_reg;
    assign m_prod = ((TW+CHW)'(oms) << CHW) - (TW+CHW)'(oms);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            x1_valid_reg <= 1'b0;
        else if (adv)
            x1_valid_reg <= h3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_sw_reg     <= SW'(h3_s_reg) * SW'(weight);
            x1_oms_reg    <= oms;
            x1_m_reg      <= m_prod[F +: CHW];
            x1_sector_reg <= h3_sector_reg;
            x1_over_reg   <= h3_over_reg;
            x1_rim_reg    <= h3_rim_reg;
            x1_gray_reg   <= h3_gray_reg;
            x1_pix_reg    <= h3_pix_reg;
        end
    end

    // ------------------------------------------------------------------
    // Ramp channel x, sector mux, black cases, output register
    // ------------------------------------------------------------------
    logic [XSW-1:0] x_sum;
    logic [CHW-1:0] x_chan;
    logic [CHW-1:0] c_chan;
    logic [CHW-1:0] red_next;
    logic [CHW-1:0] green_next;
    logic [CHW-1:0] blue_next;
    logic [CHW-1:0] red_reg;
    logic [CHW-1:0] green_reg;
    logic [CHW-1:0] blue_reg;
    logic [PW-1:0]  pix_reg;

    assign x_sum  = ((XSW'(x1_sw_reg) << CHW) - XSW'(x1_sw_reg))
                  + ((((XSW'(x1_oms_reg) << CHW) - XSW'(x1_oms_reg))) << F);
    assign x_chan = x_sum[2*F +: CHW];
    assign c_chan = icm_pkg::CHAN_MAX;

    always_comb
    begin
        red_next   = '0;
        green_next = '0;
        blue_next  = '0;
        if (mode_reg == icm_pkg::MODE_GRAY)
        begin
            red_next   = x1_gray_reg;
            green_next = x1_gray_reg;
            blue_next  = x1_gray_reg;
        end
        else if (!x1_over_reg && !x1_rim_reg)
        begin
            case (x1_sector_reg)
                3'd0:    begin red_next = c_chan;   green_next = x_chan;   blue_next = x1_m_reg; end
                3'd1:    begin red_next = x_chan;   green_next = c_chan;   blue_next = x1_m_reg; end
                3'd2:    begin red_next = x1_m_reg; green_next = c_chan;   blue_next = x_chan;   end
                3'd3:    begin red_next = x1_m_reg; green_next = x_chan;   blue_next = c_chan;   end
                3'd4:    begin red_next = x_chan;   green_next = x1_m_reg; blue_next = c_chan;   end
                default: begin red_next = c_chan;   green_next = x1_m_reg; blue_next = x_chan;   end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= x1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            pix_reg   <= x1_pix_reg;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.out_pixel_index = pix_reg;
    assign out_ch.red             = red_reg;
    assign out_ch.green           = green_reg;
    assign out_ch.blue            = blue_reg;

endmodule

### rtl/icm_checker.sv
// ----------------------------------------------------------------------------
// icm_checker
// Port-level checks for the iteration to color mapper, bound to the core.
// ----------------------------------------------------------------------------
module icm_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [icm_pkg::CHAN_W-1:0]     red,
    input logic [icm_pkg::CHAN_W-1:0]     green,
    input logic [icm_pkg::CHAN_W-1:0]     blue,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite,
    input logic [icm_pkg::APB_ADDR_W-1:0] paddr,
    input logic [icm_pkg::APB_DATA_W-1:0] pwdata
);
    // shadow of the color mode register
    logic [1:0] mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= icm_pkg::MODE_HSV;
        else if (psel && penable && pwrite &&
                 paddr[icm_pkg::APB_ADDR_W-1:2] == icm_pkg::REG_MODE)
            mode_reg <= pwdata[1:0];
    end

    // a shown result stays until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // input back-pressure only comes from a held output
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back-pressure");

    // gray mode drives equal channels
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mode_reg == icm_pkg::MODE_GRAY |-> red == green && green == blue)
        else $error("gray result with unequal channels");

endmodule

bind iteration_to_color_mapper_core icm_checker u_icm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .red      (out_ch.red),
    .green    (out_ch.green),
    .blue     (out_ch.blue),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata)
);
